[design/qle_pkg.sv]
// Shared types, constants and helper functions of the tabular Q-learning engine.
package qle_pkg;

  // Default table geometry.
  localparam int unsigned STATES_DEF  = 64;
  localparam int unsigned ACTIONS_DEF = 8;

  // Fixed field widths.
  localparam int VAL_W      = 24;
  localparam int RATE_W     = 16;
  localparam int CNT_W      = 4;
  localparam int ROW_W      = 6;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT  = 2'd2;

  // Configuration reset values.
  localparam logic [RATE_W-1:0] LEARNING_RATE_RST = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST      = 16'd58982;
  localparam logic [CNT_W-1:0]  ACTION_COUNT_RST  = 4'd8;

  // Request kinds.
  localparam logic KIND_DECIDE = 1'b0;
  localparam logic KIND_TRAIN  = 1'b1;

  // Q11.12 limits and the starting value of the row maximum (-500.0).
  localparam logic signed [VAL_W-1:0] QMAX_FLOOR = -24'sd2048000;
  localparam logic signed [VAL_W-1:0] VAL_MAX    = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN    = 24'sh800000;

  typedef logic signed [VAL_W-1:0] qval_t;

  // Result of the update unit.
  typedef struct packed {
    logic  done;
    qval_t value;
    logic  sat;
  } upd_res_t;

  // Reduces a narrow index modulo m by restoring compare and subtract steps.
  function automatic logic [ROW_W-1:0] reduce_mod(input logic [ROW_W-1:0] v,
                                                  input int unsigned m);
    logic [ROW_W-1:0] r;
    int               i;
    r = v;
    for (i = ROW_W - 1; i >= 0; i--) begin
      if (32'(r) >= (m << i)) begin
        r = r - ROW_W'(m << i);
      end
    end
    return r;
  endfunction

endpackage

[design/qle_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module qle_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem_r[ra];
    end
  end

  assign rd = rd_r;

endmodule

[design/qle_update.sv]
// Pipelined Q-learning update: difference, split multiply, rounding and saturation.
module qle_update (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  qle_pkg::qval_t                 reward,
  input  logic [qle_pkg::RATE_W-1:0]     discount,
  input  logic [qle_pkg::RATE_W-1:0]     learning_rate,
  input  qle_pkg::qval_t                 max_val,
  input  qle_pkg::qval_t                 q_val,
  output qle_pkg::upd_res_t              res
);

  localparam int LAT    = 6;
  localparam int DM_W   = qle_pkg::VAL_W + qle_pkg::RATE_W + 1;
  localparam int DIFF_W = DM_W + 1;
  localparam int LO_W   = DIFF_W / 2;
  localparam int HI_W   = DIFF_W - LO_W;
  localparam int LR_W   = qle_pkg::RATE_W + 1;
  localparam int PLO_W  = LO_W + 1 + LR_W;
  localparam int PHI_W  = HI_W + LR_W;
  localparam int SUM_W  = DIFF_W + qle_pkg::RATE_W + 2;
  localparam int STEP_W = SUM_W - 32;
  localparam int NV_W   = STEP_W + 1;

  logic [LAT-1:0]             vld_r;
  qle_pkg::qval_t             q_r;
  qle_pkg::qval_t             rew_r;
  qle_pkg::qval_t             mx_r;
  logic [qle_pkg::RATE_W-1:0] disc_r;
  logic signed [DM_W-1:0]     dm_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [DIFF_W-1:0]   diff_nxt;
  logic signed [PLO_W-1:0]    plo_r;
  logic signed [PHI_W-1:0]    phi_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [STEP_W-1:0]   step_r;
  logic signed [NV_W-1:0]     nv_sum;
  qle_pkg::qval_t             value_r;
  logic                       sat_r;
  logic signed [LR_W-1:0]     lr_s;

  assign lr_s = $signed({1'b0, learning_rate});

  always_comb begin
    diff_nxt = $signed({{(DIFF_W - qle_pkg::VAL_W - 16){rew_r[qle_pkg::VAL_W-1]}}, rew_r, 16'd0})
             + DIFF_W'(dm_r)
             - $signed({{(DIFF_W - qle_pkg::VAL_W - 16){q_r[qle_pkg::VAL_W-1]}}, q_r, 16'd0});
    // Rounding adds one half of the dropped 32 fraction bits before the floor.
    sum_nxt  = (SUM_W'(phi_r) <<< LO_W) + SUM_W'(plo_r) + (SUM_W'(1) <<< 31);
    nv_sum   = NV_W'(q_r) + NV_W'(step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r    <= q_val;
      rew_r  <= reward;
      mx_r   <= max_val;
      disc_r <= discount;
    end
    dm_r   <= $signed({1'b0, disc_r}) * mx_r;
    diff_r <= diff_nxt;
    plo_r  <= $signed({1'b0, diff_r[LO_W-1:0]}) * lr_s;
    phi_r  <= $signed(diff_r[DIFF_W-1:LO_W]) * lr_s;
    step_r <= sum_nxt[SUM_W-1:32];
    if (nv_sum > NV_W'(qle_pkg::VAL_MAX)) begin
      value_r <= qle_pkg::VAL_MAX;
      sat_r   <= 1'b1;
    end else if (nv_sum < NV_W'(qle_pkg::VAL_MIN)) begin
      value_r <= qle_pkg::VAL_MIN;
      sat_r   <= 1'b1;
    end else begin
      value_r <= nv_sum[qle_pkg::VAL_W-1:0];
      sat_r   <= 1'b0;
    end
  end

  assign res.done  = vld_r[LAT-1];
  assign res.value = value_r;
  assign res.sat   = sat_r;

endmodule

[design/tabular_q_learning_engine_top.sv]
// Top level of the tabular Q-learning engine: sequencer, row scan and Q table.
//
// The engine keeps a STATES x ACTIONS table of signed Q11.12 values in one
// synchronous RAM and serves one request at a time. A request is taken when
// start is high while busy is low; busy then stays high until the single
// result is shown on the out_ ports for one cycle, marked by out_valid, and
// busy is low again in that cycle. The receiver cannot stall, so the result
// must be captured in that cycle. A request scans action_count entries of
// one row, capped at ACTIONS. The RAM's single read port reads one table
// entry a cycle during the row scan, and the six-stage update pipeline forms
// the difference, multiplies it in two halves, rounds and saturates. After
// reset the engine clears the table one entry a cycle, all STATES * ACTIONS
// entries (512 at the default size); busy is high and no request is taken
// during that pass, while configuration writes are taken at any time.
// Configuration should only be changed while the engine is idle.
module tabular_q_learning_engine_top #(
  parameter int unsigned STATES  = qle_pkg::STATES_DEF,
  parameter int unsigned ACTIONS = qle_pkg::ACTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [qle_pkg::ROW_W-1:0]         in_state_index,
  input  logic [qle_pkg::ACT_W-1:0]         in_action_index,
  input  logic signed [qle_pkg::VAL_W-1:0]  in_reward,
  input  logic [qle_pkg::ROW_W-1:0]         in_next_state_index,
  output logic                              out_valid,
  output logic [qle_pkg::ACT_W-1:0]         out_best_action,
  output logic signed [qle_pkg::VAL_W-1:0]  out_updated_value,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [qle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qle_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned DEPTH = STATES * ACTIONS;
  localparam int AW  = $clog2(DEPTH);
  localparam int RW  = $clog2(STATES);
  localparam int AIW = $clog2(ACTIONS);
  localparam int KW  = $clog2(ACTIONS + 1);

  localparam logic [AW-1:0] ACT_STRIDE = AW'(ACTIONS);
  localparam logic [AW-1:0] DEPTH_LAST = AW'(DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_QRD   = 3'd4;
  localparam logic [2:0] ST_QWAIT = 3'd5;
  localparam logic [2:0] ST_UPD   = 3'd6;

  logic [2:0]                   state_r;
  logic [AW-1:0]                clr_addr_r;

  // Configuration registers.
  logic [qle_pkg::RATE_W-1:0]   learning_rate_r;
  logic [qle_pkg::RATE_W-1:0]   discount_r;
  logic [qle_pkg::CNT_W-1:0]    action_count_r;

  // Captured request, with row and action indexes already folded into range.
  logic                         kind_r;
  logic [RW-1:0]                row_s_r;
  logic [RW-1:0]                row_sp_r;
  logic [AIW-1:0]               act_r;
  qle_pkg::qval_t               reward_r;
  logic [KW-1:0]                scan_n_r;

  // Row scan.
  logic [AW-1:0]                scan_base_r;
  logic [AW-1:0]                upd_addr_r;
  logic [KW-1:0]                issue_k_r;
  logic                         pend_r;
  logic [KW-1:0]                pend_k_r;
  qle_pkg::qval_t               max_r;
  logic [KW-1:0]                arg_r;

  // Result registers.
  logic                         out_valid_r;
  logic [qle_pkg::ACT_W-1:0]    out_best_action_r;
  qle_pkg::qval_t               out_updated_value_r;
  logic                         out_saturated_r;

  // RAM ports.
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  qle_pkg::qval_t               rd_data;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  qle_pkg::qval_t               mem_wd;

  logic                         accept;
  logic                         scan_rd;
  logic                         scan_done;
  logic                         upd_go;
  qle_pkg::upd_res_t            upd_res;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign scan_rd = (state_r == ST_SCAN) && (issue_k_r < scan_n_r);

  // The scan is finished once every entry has been read and the last read
  // has been compared against the running maximum.
  assign scan_done = (state_r == ST_SCAN) && (issue_k_r == scan_n_r) && !pend_r;
  assign upd_go    = (state_r == ST_QWAIT);

  always_comb begin
    rd_en   = scan_rd || (state_r == ST_QRD);
    rd_addr = (state_r == ST_QRD) ? upd_addr_r : scan_base_r + AW'(issue_k_r);
    mem_we  = (state_r == ST_CLEAR) || ((state_r == ST_UPD) && upd_res.done);
    mem_wa  = (state_r == ST_CLEAR) ? clr_addr_r : upd_addr_r;
    mem_wd  = (state_r == ST_CLEAR) ? '0 : upd_res.value;
  end

  qle_ram #(
    .WIDTH (qle_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_qtable (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (rd_data)
  );

  // The update unit sees the stored Q value in the cycle after its read.
  qle_update u_update (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (upd_go),
    .reward        (reward_r),
    .discount      (discount_r),
    .learning_rate (learning_rate_r),
    .max_val       (max_r),
    .q_val         (rd_data),
    .res           (upd_res)
  );

  // Configuration writes are taken at any time; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r <= qle_pkg::LEARNING_RATE_RST;
      discount_r      <= qle_pkg::DISCOUNT_RST;
      action_count_r  <= qle_pkg::ACTION_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qle_pkg::CFG_LEARNING_RATE: learning_rate_r <= cfg_data;
        qle_pkg::CFG_DISCOUNT:      discount_r      <= cfg_data;
        qle_pkg::CFG_ACTION_COUNT:  action_count_r  <= cfg_data[qle_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      issue_k_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == DEPTH_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          issue_k_r <= '0;
          pend_r    <= 1'b0;
          state_r   <= ST_SCAN;
        end
        ST_SCAN: begin
          pend_r <= scan_rd;
          if (scan_rd) begin
            issue_k_r <= issue_k_r + KW'(1);
          end
          if (scan_done) begin
            if (kind_r == qle_pkg::KIND_DECIDE) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_QRD;
            end
          end
        end
        ST_QRD: begin
          state_r <= ST_QWAIT;
        end
        ST_QWAIT: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_res.done) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture, scan datapath and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      row_s_r  <= RW'(qle_pkg::reduce_mod(in_state_index, STATES));
      row_sp_r <= RW'(qle_pkg::reduce_mod(in_next_state_index, STATES));
      act_r    <= AIW'(qle_pkg::reduce_mod({3'b000, in_action_index}, ACTIONS));
      reward_r <= in_reward;
      if (32'(action_count_r) > ACTIONS) begin
        scan_n_r <= KW'(ACTIONS);
      end else begin
        scan_n_r <= KW'(action_count_r);
      end
    end

    if (state_r == ST_SETUP) begin
      // A train request scans the next state's row; a decide scans its own.
      scan_base_r <= AW'((kind_r == qle_pkg::KIND_TRAIN) ? row_sp_r : row_s_r) * ACT_STRIDE;
      upd_addr_r  <= AW'(row_s_r) * ACT_STRIDE + AW'(act_r);
      max_r       <= qle_pkg::QMAX_FLOOR;
      arg_r       <= '0;
    end

    if (state_r == ST_SCAN) begin
      pend_k_r <= issue_k_r;
      // Strictly greater only, so ties keep the lowest action.
      if (pend_r && (rd_data > max_r)) begin
        max_r <= rd_data;
        arg_r <= pend_k_r;
      end
    end

    if (scan_done && (kind_r == qle_pkg::KIND_DECIDE)) begin
      out_best_action_r   <= qle_pkg::ACT_W'(arg_r);
      out_updated_value_r <= '0;
      out_saturated_r     <= 1'b0;
    end else if ((state_r == ST_UPD) && upd_res.done) begin
      out_best_action_r   <= '0;
      out_updated_value_r <= upd_res.value;
      out_saturated_r     <= upd_res.sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_action   = out_best_action_r;
  assign out_updated_value = out_updated_value_r;
  assign out_saturated     = out_saturated_r;

  // A result only follows a cycle in which a request was in progress.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  // An accepted request keeps the engine busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("engine not busy after accepting a request");

  // The table is written only by the clearing pass or by a finished update.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_CLEAR) || (state_r == ST_UPD)))
    else $error("table write outside clearing or update");

  // The update unit finishes only while the sequencer waits for it.
  a_update_in_place: assert property (@(posedge clk) disable iff (!rst_n)
    upd_res.done |-> (state_r == ST_UPD))
    else $error("update result while sequencer is not waiting");

endmodule
